/* rtl/core/dtf_pkg.sv */
// Shared constants, types and helpers for the deduplicating triple queue.
package dtf_pkg;

    localparam int QUEUE_DEPTH = 16;

    localparam int PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int FIELD_W    = 16;
    localparam int KEY_W      = 3 * FIELD_W;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 5;
    localparam int IN_TDATA_W = ((KEY_W + 7) / 8) * 8;
    localparam int OUT_BITS   = KEY_W + OCC_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_TDATA_W - OUT_BITS;

    // Operation codes carried in the input tuser
    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    // Status codes carried in the output tuser
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [KEY_W-1:0] t_key;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            scan_done;
        logic            out_free;
    } t_dp_sts;

    function automatic t_ptr next_ptr(input t_ptr p);
        t_ptr r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

/* rtl/core/dedup_triple_fifo_unit.sv */
// Top level of the deduplicating triple queue: controller plus datapath.
//
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid/s_axis_tready  tuser: operation; tdata: triple
//  m_axis   out  m_axis_tvalid/m_axis_tready  tuser: status; tdata: head triple, occupancy
//
// Each operation passes through accept, dispatch and commit; an enqueue adds a scan of
// the entries held, one store read per cycle. The result is registered at commit.
// One operation is in flight at a time; a waiting result holds only the commit,
// not the next transfer. Reset (synchronous, active low) empties the queue;
// stored entries are not cleared.
module dedup_triple_fifo_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] first_interval, [31:16] second_interval, [47:32] relation_set
    input  logic [dtf_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [1:0] operation
    input  logic [dtf_pkg::OP_W-1:0]            s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] head_first, [31:16] head_second, [47:32] head_relations,
    // [52:48] occupancy, rest zero
    output logic [dtf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [1:0] status
    output logic [dtf_pkg::STATUS_W-1:0]        m_axis_tuser
);

    dtf_pkg::t_dp_cmd w_cmd;
    dtf_pkg::t_dp_sts w_sts;

    dtf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    dtf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_op        (s_axis_tuser),
        .i_key       (s_axis_tdata[dtf_pkg::KEY_W-1:0]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_status    (m_axis_tuser),
        .o_out_data  (m_axis_tdata)
    );

endmodule

/* rtl/core/dtf_ctrl.sv */
// Sequencer for the triple queue: accept, dispatch, duplicate scan, commit.
module dtf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  dtf_pkg::t_dp_sts i_sts,
    output dtf_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_DISPATCH = 4'b0010,
        S_SCAN     = 4'b0100,
        S_FINISH   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                // head entry is read during this cycle for a dequeue
                if (i_sts.op == dtf_pkg::OP_ENQUEUE) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/dtf_datapath.sv */
// Entry store, queue pointers, duplicate compare and output register.
module dtf_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dtf_pkg::t_dp_cmd                 i_cmd,
    output dtf_pkg::t_dp_sts                 o_sts,
    input  logic [dtf_pkg::OP_W-1:0]         i_op,
    input  dtf_pkg::t_key                    i_key,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [dtf_pkg::STATUS_W-1:0]     o_status,
    output logic [dtf_pkg::OUT_TDATA_W-1:0]  o_out_data
);

    dtf_pkg::t_key r_mem [dtf_pkg::QUEUE_DEPTH];

    dtf_pkg::t_ptr r_head;
    dtf_pkg::t_ptr r_tail;
    dtf_pkg::t_cnt r_count;
    dtf_pkg::t_ptr r_scan_ptr;
    dtf_pkg::t_cnt r_scan_left;
    logic          r_rd_valid;
    logic          r_hit;
    logic [dtf_pkg::OP_W-1:0] r_op;
    dtf_pkg::t_key r_key;
    dtf_pkg::t_key r_rd_data;

    logic                          r_out_valid;
    logic [dtf_pkg::STATUS_W-1:0]  r_out_status;
    dtf_pkg::t_key                 r_out_heads;
    logic [dtf_pkg::OCC_W-1:0]     r_out_occ;

    dtf_pkg::t_ptr                 n_head;
    dtf_pkg::t_ptr                 n_tail;
    dtf_pkg::t_cnt                 n_count;
    logic [dtf_pkg::STATUS_W-1:0]  n_status;
    dtf_pkg::t_key                 n_heads;
    logic                          n_wr_en;

    // Result of the committed operation
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_status = dtf_pkg::ST_DONE;
        n_heads  = '0;
        n_wr_en  = 1'b0;
        case (r_op)
            dtf_pkg::OP_ENQUEUE: begin
                // duplicate check wins over the full check
                if (r_hit) begin
                    n_status = dtf_pkg::ST_DUPLICATE;
                end else if (r_count == dtf_pkg::CNT_W'(dtf_pkg::QUEUE_DEPTH)) begin
                    n_status = dtf_pkg::ST_FULL;
                end else begin
                    n_wr_en = 1'b1;
                    n_tail  = dtf_pkg::next_ptr(r_tail);
                    n_count = r_count + 1'b1;
                end
            end
            dtf_pkg::OP_DEQUEUE: begin
                if (r_count == '0) begin
                    n_status = dtf_pkg::ST_EMPTY;
                end else begin
                    n_heads = r_rd_data;
                    n_head  = dtf_pkg::next_ptr(r_head);
                    n_count = r_count - 1'b1;
                end
            end
            dtf_pkg::OP_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            default: begin
                n_status = dtf_pkg::ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && n_wr_en) begin
            r_mem[r_tail] <= r_key;
        end
        r_rd_data <= r_mem[r_scan_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_key;
        end
        if (i_cmd.commit) begin
            r_out_status <= n_status;
            r_out_heads  <= n_heads;
            r_out_occ    <= dtf_pkg::OCC_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_scan_ptr  <= '0;
            r_scan_left <= '0;
            r_rd_valid  <= 1'b0;
            r_hit       <= 1'b0;
            r_op        <= dtf_pkg::OP_ENQUEUE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_op        <= i_op;
                r_scan_ptr  <= r_head;
                r_scan_left <= r_count;
                r_rd_valid  <= 1'b0;
                r_hit       <= 1'b0;
            end
            if (i_cmd.scan) begin
                // one read issued, one compare retired per cycle
                if (r_scan_left != '0) begin
                    r_scan_ptr  <= dtf_pkg::next_ptr(r_scan_ptr);
                    r_scan_left <= r_scan_left - 1'b1;
                    r_rd_valid  <= 1'b1;
                end else begin
                    r_rd_valid  <= 1'b0;
                end
                if (r_rd_valid && (r_rd_data == r_key)) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.scan_done = (r_scan_left == '0) && !r_rd_valid;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_out_data  = {{dtf_pkg::OUT_PAD_W{1'b0}}, r_out_occ, r_out_heads};

endmodule
